[rtl/core/ymodem_packet_receiver_unit_assert.svh]
// ----------------------------------------------------------------------------
// ymodem packet receiver assertion macros
// shorthand for the concurrent checks on the receiver ports
// ----------------------------------------------------------------------------
`ifndef YMODEM_PACKET_RECEIVER_UNIT_ASSERT_SVH
`define YMODEM_PACKET_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define YMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ymodem receiver check failed");

// next-cycle implication, off during reset
`define YMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ymodem receiver check failed");

`endif

[rtl/core/ymr_pkg.sv]
// ----------------------------------------------------------------------------
// ymr_pkg
// types and constants shared by the ymodem packet receiver
// ----------------------------------------------------------------------------
package ymr_pkg;

    localparam int unsigned SHORT_BLOCK = 128;
    localparam int unsigned LONG_BLOCK  = 1024;
    localparam int unsigned COUNT_W     = $clog2(LONG_BLOCK + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [8:0]  NUM_CHECK     = 9'h0FF;

    localparam logic [7:0] H_SOH = 8'h01;
    localparam logic [7:0] H_STX = 8'h02;
    localparam logic [7:0] H_EOT = 8'h04;
    localparam logic [7:0] H_ACK = 8'h06;
    localparam logic [7:0] H_NAK = 8'h15;
    localparam logic [7:0] H_CAN = 8'h18;
    localparam logic [7:0] H_C   = 8'h43;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CHECK   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [9:0] byte_index;
        logic [1:0] status;
        logic [7:0] header_code;
        logic [7:0] block_number;
    } out_item_t;

endpackage

[rtl/core/ymr_crc.sv]
// ----------------------------------------------------------------------------
// ymr_crc
// byte-wide crc-16/xmodem update, msb first
// ----------------------------------------------------------------------------
module ymr_crc
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ ymr_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

[rtl/core/ymr_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// ymr_frame_ctrl
// frame state machine, tick timer and result register
// ----------------------------------------------------------------------------
module ymr_frame_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ymr_pkg::in_item_t  item,
    input  logic [15:0]        timeout_ticks,
    input  logic               out_ready,
    output logic               out_valid,
    output ymr_pkg::out_item_t out_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NUM,
        PH_CMP,
        PH_DATA,
        PH_CRCH,
        PH_CRCL
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic                           long_block_reg, long_block_next;
    logic [7:0]                     header_reg, header_next;
    logic [7:0]                     number_reg, number_next;
    logic [7:0]                     complement_reg, complement_next;
    logic [ymr_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [7:0]                     crc_high_reg, crc_high_next;
    logic [15:0]                    ticks_reg, ticks_next;
    logic                           res_valid_reg, res_valid_next;
    ymr_pkg::out_item_t             res_reg, res_next;

    logic [15:0]                    crc_upd;
    logic [ymr_pkg::COUNT_W-1:0]    count_inc;
    logic [ymr_pkg::COUNT_W-1:0]    block_len;
    logic                           num_ok;

    ymr_crc u_crc
    (
        .crc_in  (crc_reg),
        .data    (item.rx_byte),
        .crc_out (crc_upd)
    );

    assign count_inc = count_reg + 1'b1;
    assign block_len = long_block_reg ? ymr_pkg::COUNT_W'(ymr_pkg::LONG_BLOCK)
                                      : ymr_pkg::COUNT_W'(ymr_pkg::SHORT_BLOCK);
    assign num_ok    = ({1'b0, number_reg} + {1'b0, complement_reg}) == ymr_pkg::NUM_CHECK;

    always_comb
    begin
        phase_next      = phase_reg;
        long_block_next = long_block_reg;
        header_next     = header_reg;
        number_next     = number_reg;
        complement_next = complement_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        ticks_next      = ticks_reg;
        res_valid_next  = res_valid_reg && !out_ready;
        res_next        = res_reg;

        if (step)
        begin
            res_next              = '0;
            res_next.kind         = ymr_pkg::KIND_RESULT;
            res_next.header_code  = header_reg;
            res_next.block_number = number_reg;

            if (item.func == ymr_pkg::FUNC_TICK)
            begin
                if (ticks_reg > 16'd1)
                begin
                    ticks_next = ticks_reg - 16'd1;
                end
                else
                begin
                    res_valid_next    = 1'b1;
                    res_next.status   = ymr_pkg::ST_TIMEOUT;
                    phase_next        = PH_IDLE;
                    header_next       = '0;
                    number_next       = '0;
                    ticks_next        = timeout_ticks;
                end
            end
            else
            begin
                ticks_next = timeout_ticks;
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (item.rx_byte == ymr_pkg::H_SOH || item.rx_byte == ymr_pkg::H_STX)
                        begin
                            header_next     = item.rx_byte;
                            long_block_next = (item.rx_byte == ymr_pkg::H_STX);
                            number_next     = '0;
                            complement_next = '0;
                            count_next      = '0;
                            crc_next        = '0;
                            crc_high_next   = '0;
                            phase_next      = PH_NUM;
                        end
                        else
                        begin
                            res_valid_next        = 1'b1;
                            res_next.header_code  = item.rx_byte;
                            res_next.block_number = '0;
                            if (item.rx_byte == ymr_pkg::H_EOT || item.rx_byte == ymr_pkg::H_ACK
                                || item.rx_byte == ymr_pkg::H_NAK
                                || item.rx_byte == ymr_pkg::H_CAN
                                || item.rx_byte == ymr_pkg::H_C)
                            begin
                                res_next.status = ymr_pkg::ST_OK;
                            end
                            else
                            begin
                                res_next.status = ymr_pkg::ST_UNKNOWN;
                            end
                            phase_next  = PH_IDLE;
                            header_next = '0;
                            number_next = '0;
                        end
                    end
                    PH_NUM:
                    begin
                        number_next = item.rx_byte;
                        phase_next  = PH_CMP;
                    end
                    PH_CMP:
                    begin
                        complement_next = item.rx_byte;
                        phase_next      = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        res_valid_next        = 1'b1;
                        res_next.kind         = ymr_pkg::KIND_DATA;
                        res_next.payload_byte = item.rx_byte;
                        res_next.byte_index   = count_reg[9:0];
                        res_next.status       = ymr_pkg::ST_OK;
                        crc_next              = crc_upd;
                        count_next            = count_inc;
                        if (count_inc >= block_len)
                        begin
                            phase_next = PH_CRCH;
                        end
                    end
                    PH_CRCH:
                    begin
                        crc_high_next = item.rx_byte;
                        phase_next    = PH_CRCL;
                    end
                    PH_CRCL:
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = (num_ok && crc_reg == {crc_high_reg, item.rx_byte})
                                          ? ymr_pkg::ST_OK : ymr_pkg::ST_CHECK;
                        phase_next      = PH_IDLE;
                        header_next     = '0;
                        number_next     = '0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            long_block_reg <= 1'b0;
            header_reg     <= '0;
            number_reg     <= '0;
            complement_reg <= '0;
            count_reg      <= '0;
            crc_reg        <= '0;
            crc_high_reg   <= '0;
            ticks_reg      <= ymr_pkg::TIMEOUT_RESET;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            long_block_reg <= long_block_next;
            header_reg     <= header_next;
            number_reg     <= number_next;
            complement_reg <= complement_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
            ticks_reg      <= ticks_next;
            res_valid_reg  <= res_valid_next;
            res_reg        <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

[rtl/core/ymodem_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// ymodem_packet_receiver_unit
// ymodem crc-16 frame receiver: payload bytes with index, then a frame status
// ----------------------------------------------------------------------------
// One item (a received byte or a timer tick) is taken every clock while
// in_ready is high. An item lands in the input register; the frame logic and
// the byte crc then update on it and load the result register, which holds
// its result until out_ready takes it.
// in_ready falls only while both the input and the result register are full
// and out_ready is low. The timeout register is written at any clock through
// the cfg channel and takes effect at the next timer reload.
module ymodem_packet_receiver_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ymr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ymr_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    logic              s1_valid_reg, s1_valid_next;
    ymr_pkg::in_item_t s1_item_reg, s1_item_next;
    logic [15:0]       timeout_reg, timeout_next;
    logic              res_free;
    logic              step;

    assign res_free  = !out_valid || out_ready;
    assign step      = s1_valid_reg && res_free;
    assign in_ready  = !s1_valid_reg || res_free;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !step;
        s1_item_next  = s1_item_reg;
        timeout_next  = timeout_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
            s1_item_next  = in_data;
        end
        if (cfg_valid)
        begin
            timeout_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_item_reg  <= '0;
            timeout_reg  <= ymr_pkg::TIMEOUT_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_item_reg  <= s1_item_next;
            timeout_reg  <= timeout_next;
        end
    end

    ymr_frame_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (s1_item_reg),
        .timeout_ticks (timeout_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_data      (out_data)
    );

endmodule

[rtl/core/ymr_checker.sv]
// ----------------------------------------------------------------------------
// ymr_checker
// port-level checks on the receiver result channel
// ----------------------------------------------------------------------------
`include "ymodem_packet_receiver_unit_assert.svh"

module ymr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input ymr_pkg::out_item_t out_data
);

    `YMR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `YMR_ASSERT_IMP(a_data_ok, clk, rst_n, out_valid && out_data.kind == ymr_pkg::KIND_DATA, out_data.status == ymr_pkg::ST_OK)
    `YMR_ASSERT_IMP(a_result_clean, clk, rst_n, out_valid && out_data.kind == ymr_pkg::KIND_RESULT, out_data.payload_byte == 8'd0 && out_data.byte_index == 10'd0)
    `YMR_ASSERT_IMP(a_unknown_nonum, clk, rst_n, out_valid && out_data.status == ymr_pkg::ST_UNKNOWN, out_data.kind == ymr_pkg::KIND_RESULT && out_data.block_number == 8'd0)

endmodule

bind ymodem_packet_receiver_unit ymr_checker u_ymr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[test/ymodem_receiver_checker.sv]
// ----------------------------------------------------------------------------
// ymodem receiver checker
// follows the byte and tick items into the receiver, predicts every payload
// byte and frame status, and compares them in order with the result items
// ----------------------------------------------------------------------------
package ymr_crc_pkg;

    function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc,
                                                      input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            acc = acc[15] ? ((acc << 1) ^ ymr_pkg::CRC_POLY) : (acc << 1);
        end
        return acc;
    endfunction

endpackage

module ymodem_receiver_checker
    import ymr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [15:0] cfg_data,
    output int        mismatches,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        AWAIT_HEADER,
        AWAIT_NUMBER,
        AWAIT_COMPLEMENT,
        IN_PAYLOAD,
        AWAIT_CRC_HIGH,
        AWAIT_CRC_LOW
    } rx_phase_t;

    rx_phase_t   rx_phase;
    logic [15:0] timeout_ticks;
    logic [15:0] ticks_left;
    logic        long_block;
    logic [7:0]  header_held;
    logic [7:0]  number_held;
    logic [7:0]  complement_held;
    logic [10:0] byte_count;
    logic [15:0] frame_crc;
    logic [7:0]  crc_high_held;

    out_item_t   frame_results_q[$];

    function automatic void drop_frame();
        rx_phase    = AWAIT_HEADER;
        header_held = '0;
        number_held = '0;
    endfunction

    function automatic bit predict_receiver(input in_item_t item, output out_item_t res);
        logic [10:0] blk_len;
        logic [7:0]  b;
        logic        frame_ok;
        res = '0;
        b   = item.rx_byte;
        if (item.func == FUNC_TICK)
        begin
            if (ticks_left > 16'd1)
            begin
                ticks_left--;
                return 1'b0;
            end
            res.kind         = KIND_RESULT;
            res.status       = ST_TIMEOUT;
            res.header_code  = header_held;
            res.block_number = number_held;
            drop_frame();
            ticks_left = timeout_ticks;
            return 1'b1;
        end
        ticks_left = timeout_ticks;
        case (rx_phase)
            AWAIT_HEADER:
            begin
                if (b == H_SOH || b == H_STX)
                begin
                    header_held     = b;
                    long_block      = (b == H_STX);
                    number_held     = '0;
                    complement_held = '0;
                    byte_count      = '0;
                    frame_crc       = '0;
                    crc_high_held   = '0;
                    rx_phase        = AWAIT_NUMBER;
                    return 1'b0;
                end
                res.kind        = KIND_RESULT;
                res.header_code = b;
                if (b == H_EOT || b == H_ACK || b == H_NAK || b == H_CAN || b == H_C)
                    res.status = ST_OK;
                else
                    res.status = ST_UNKNOWN;
                drop_frame();
                return 1'b1;
            end
            AWAIT_NUMBER:
            begin
                number_held = b;
                rx_phase    = AWAIT_COMPLEMENT;
                return 1'b0;
            end
            AWAIT_COMPLEMENT:
            begin
                complement_held = b;
                rx_phase        = IN_PAYLOAD;
                return 1'b0;
            end
            IN_PAYLOAD:
            begin
                blk_len          = long_block ? 11'(LONG_BLOCK) : 11'(SHORT_BLOCK);
                res.kind         = KIND_DATA;
                res.payload_byte = b;
                res.byte_index   = byte_count[9:0];
                res.status       = ST_OK;
                res.header_code  = header_held;
                res.block_number = number_held;
                frame_crc        = ymr_crc_pkg::crc16_xmodem_byte(frame_crc, b);
                byte_count++;
                if (byte_count >= blk_len)
                    rx_phase = AWAIT_CRC_HIGH;
                return 1'b1;
            end
            AWAIT_CRC_HIGH:
            begin
                crc_high_held = b;
                rx_phase      = AWAIT_CRC_LOW;
                return 1'b0;
            end
            default:
            begin
                // the number check is a plain sum, no wrap
                frame_ok = (9'(number_held) + 9'(complement_held) == NUM_CHECK) &&
                           (frame_crc == {crc_high_held, b});
                res.kind         = KIND_RESULT;
                res.status       = frame_ok ? ST_OK : ST_CHECK;
                res.header_code  = header_held;
                res.block_number = number_held;
                drop_frame();
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input out_item_t got,
                                   input out_item_t want);
        if (mismatches < 30)
            $display("%0t: result item%s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input out_item_t got, input out_item_t want);
        string diffs;
        diffs = "";
        if (got.kind != want.kind)
            diffs = {diffs, " kind"};
        if (got.payload_byte != want.payload_byte)
            diffs = {diffs, " payload_byte"};
        if (got.byte_index != want.byte_index)
            diffs = {diffs, " byte_index"};
        if (got.status != want.status)
            diffs = {diffs, " status"};
        if (got.header_code != want.header_code)
            diffs = {diffs, " header_code"};
        if (got.block_number != want.block_number)
            diffs = {diffs, " block_number"};
        if (diffs != "")
            report_mismatch({" differs in", diffs}, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            timeout_ticks   = TIMEOUT_RESET;
            ticks_left      = TIMEOUT_RESET;
            rx_phase        = AWAIT_HEADER;
            long_block      = 1'b0;
            header_held     = '0;
            number_held     = '0;
            complement_held = '0;
            byte_count      = '0;
            frame_crc       = '0;
            crc_high_held   = '0;
            mismatches      = 0;
            frame_results_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_results_q.size() == 0)
                    report_mismatch(" arrived with nothing due", out_data, '0);
                else
                begin
                    want = frame_results_q.pop_front();
                    check_result(out_data, want);
                end
            end
            if (cfg_valid && cfg_ready)
                timeout_ticks = cfg_data;
            if (in_valid && in_ready)
            begin
                if (predict_receiver(in_data, want))
                    frame_results_q.push_back(want);
            end
            pending <= frame_results_q.size();
        end
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// ymodem packet receiver testbench
// drives commands, unknown headers, whole and broken frames and timer ticks
// under several timeout settings, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ymr_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam logic [7:0] COMMANDS [5] = '{H_EOT, H_ACK, H_NAK, H_CAN, H_C};

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int mismatches;
    int pending;

    bit          calm = 1'b0;
    logic [15:0] timeout_now = TIMEOUT_RESET;
    int          items_sent;
    int          settings_used;
    int          frames_sent;
    int          long_frames;
    int          bad_frames;
    int          cut_frames;
    int          single_bytes;
    int          quiet_cycles;

    ymodem_packet_receiver_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ymodem_receiver_checker i_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ymodem_packet_receiver_unit: mismatch");
            $finish;
        end
    end

    // result side: short random stalls and one long hold-off
    initial
    begin
        int  seen;
        bit  held;
        seen = 0;
        held = 1'b0;
        forever
        begin
            if (!held && seen >= 100)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
                seen++;
        end
    end

    task automatic send_item(input in_item_t item);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{func: FUNC_BYTE, rx_byte: b});
    endtask

    task automatic send_tick();
        send_item('{func: FUNC_TICK, rx_byte: 8'($urandom)});
    endtask

    task automatic expire();
        repeat ((timeout_now == 16'd0) ? 1 : int'(timeout_now)) send_tick();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // items with no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_now = ticks;
        settings_used++;
    endtask

    task automatic send_frame(input bit long_blk, input bit bad_num, input bit bad_crc,
                              input int cut_at);
        logic [7:0]  body[$];
        logic [7:0]  num;
        logic [7:0]  b;
        logic [15:0] crc;
        int          len;
        len = long_blk ? LONG_BLOCK : SHORT_BLOCK;
        num = 8'($urandom);
        crc = '0;
        body.push_back(long_blk ? H_STX : H_SOH);
        body.push_back(num);
        body.push_back(bad_num ? (~num ^ (8'h01 << $urandom_range(0, 7))) : ~num);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            body.push_back(b);
            crc = ymr_crc_pkg::crc16_xmodem_byte(crc, b);
        end
        if (bad_crc)
            crc ^= 16'h0001 << $urandom_range(0, 15);
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        frames_sent++;
        if (long_blk)
            long_frames++;
        if (bad_num || bad_crc)
            bad_frames++;
        foreach (body[i])
        begin
            if (i == cut_at)
            begin
                cut_frames++;
                expire();
                return;
            end
            send_byte(body[i]);
            if (timeout_now >= 16'd8 && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, 3)) send_tick();
        end
    endtask

    task automatic run_phase(input int budget);
        int         start_count;
        int         pick;
        logic [7:0] b;
        start_count = items_sent;
        while (items_sent - start_count < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 7)
                send_frame(1'b0, $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0, -1);
            else if (pick < 9)
            begin
                if (timeout_now <= 16'd40)
                    send_frame($urandom_range(0, 1), 1'b0, 1'b0, $urandom_range(1, 140));
                else
                    send_frame(1'b0, 1'b0, 1'b1, -1);
            end
            else if (pick < 13)
            begin
                send_byte(COMMANDS[$urandom_range(0, 4)]);
                single_bytes++;
            end
            else if (pick < 16)
            begin
                b = 8'($urandom);
                if (b == H_SOH || b == H_STX)
                    b = 8'hFF;
                send_byte(b);
                single_bytes++;
            end
            else
                repeat ($urandom_range(1, 4)) send_tick();
        end
    endtask

    function automatic logic [15:0] pick_timeout(input int k);
        case (k % 4)
            0:       return 16'hFFFF;
            1:       return 16'd3;
            2:       return 16'd1;
            default: return 16'($urandom_range(8, 40));
        endcase
    endfunction

    initial
    begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // commands, unknown headers and idle ticks at the reset timeout
        foreach (COMMANDS[i])
            send_byte(COMMANDS[i]);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h03);
        single_bytes += 8;
        send_tick();
        send_tick();
        // new value only takes effect at the next reload
        write_timeout(16'd1);
        send_tick();
        send_byte(8'h55);
        send_tick();
        send_byte(H_SOH);
        send_tick();
        send_byte(H_STX);
        send_byte(8'hA5);
        send_tick();
        write_timeout(16'd0);
        send_tick();
        send_tick();

        write_timeout(16'hFFFF);
        send_frame(1'b1, 1'b0, 1'b0, -1);
        k = 0;
        while (items_sent < 1450)
        begin
            write_timeout(pick_timeout(k));
            run_phase(80);
            k++;
        end
        calm = 1'b1;
        write_timeout(16'($urandom_range(8, 40)));
        run_phase(100);
        settle();

        $display("%0d items under %0d timeout settings: %0d frames, %0d long, %0d corrupted",
                 items_sent, settings_used, frames_sent, long_frames, bad_frames);
        $display("%0d frames broken off by timeout, %0d command or unknown header bytes",
                 cut_frames, single_bytes);
        if (mismatches == 0 && pending == 0)
            $display("ymodem_packet_receiver_unit: match");
        else
            $display("ymodem_packet_receiver_unit: mismatch");
        $finish;
    end

endmodule
